[rtl/core/stack_with_positional_insert_remove_top_assert.svh]
// Assertion macros for the stack top level. Each macro expects signals named
// clk and rst to be visible where it is used.
`ifndef STACK_WITH_POSITIONAL_INSERT_REMOVE_TOP_ASSERT_SVH
`define STACK_WITH_POSITIONAL_INSERT_REMOVE_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SWP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SWP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/swp_pkg.sv]
`default_nettype none

package swp_pkg;

  // Number of stack slots.
  localparam int DEPTH = 16;

  // Slot index width and occupancy count width.
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Fixed field widths.
  localparam int POS_W  = 5;
  localparam int DATA_W = 32;

  // Width used when comparing a position against the count.
  localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

  typedef enum logic [2:0] {
    REQ_PUSH   = 3'd0,
    REQ_POP    = 3'd1,
    REQ_PEEK   = 3'd2,
    REQ_INSERT = 3'd3,
    REQ_REMOVE = 3'd4,
    REQ_DUMP   = 3'd5
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_INVALID = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] value;
  } swp_ctrl_t;

endpackage

`default_nettype wire

[rtl/core/swp_req_if.sv]
`default_nettype none

interface swp_req_if;
  import swp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [2:0]               req_type;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] push_value;

  modport source (output valid, output req_type, output position, output push_value,
                  input ready);
  modport sink (input valid, input req_type, input position, input push_value,
                output ready);
endinterface

`default_nettype wire

[rtl/core/swp_rsp_if.sv]
`default_nettype none

interface swp_rsp_if;
  import swp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] read_value;
  logic [CNT_W-1:0]         entry_count;
  logic                     last;

  modport source (output valid, output status, output read_value, output entry_count,
                  output last, input ready);
  modport sink (input valid, input status, input read_value, input entry_count,
                input last, output ready);
endinterface

`default_nettype wire

[rtl/core/swp_cell.sv]
`default_nettype none

module swp_cell (
  input  wire logic                             clk,
  input  wire logic [swp_pkg::IDX_W-1:0]        cell_idx,
  input  wire swp_pkg::swp_ctrl_t               ctrl,
  input  wire logic signed [swp_pkg::DATA_W-1:0] below,
  input  wire logic signed [swp_pkg::DATA_W-1:0] above,
  output      logic signed [swp_pkg::DATA_W-1:0] data
);
  import swp_pkg::*;

  // An insert opens a gap at ctrl.idx by moving the upper part up one slot;
  // a remove closes the gap at ctrl.idx by moving the upper part down.
  always_ff @(posedge clk) begin
    if (ctrl.ins && (cell_idx == ctrl.idx)) begin
      data <= ctrl.value;
    end else if (ctrl.ins && (cell_idx > ctrl.idx)) begin
      data <= below;
    end else if (ctrl.rem && (cell_idx >= ctrl.idx)) begin
      data <= above;
    end
  end

endmodule

`default_nettype wire

[rtl/core/stack_with_positional_insert_remove_top.sv]
// A result is registered in the cycle after its request is accepted.
// One request per cycle is taken while the output register is free; a dump
// of N entries blocks the request channel until its last result is registered,
// one result per cycle while the receiver is ready, set by the single read port.
// Reset (synchronous, active high) empties the stack and drops any pending
// result; the stored words are not cleared.
`default_nettype none

`include "stack_with_positional_insert_remove_top_assert.svh"

module stack_with_positional_insert_remove_top (
  input wire logic clk,
  input wire logic rst,
  swp_req_if.sink  req,
  swp_rsp_if.source rsp
);
  import swp_pkg::*;

  // The stack lives in a row of cells, slot 0 at the bottom. For each request
  // the control logic decides whether the row opens a gap (push or insert),
  // closes one (pop or remove) or holds, and broadcasts that decision to all
  // cells, which each look only at their two neighbors.
  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_t;

  state_t                   state;
  logic [CNT_W-1:0]         fill_count;
  logic [IDX_W-1:0]         dump_idx;

  // Output register; a new request is taken in the cycle that the pending
  // result leaves.
  logic                     rsp_valid;
  logic [1:0]               rsp_status;
  logic signed [DATA_W-1:0] rsp_read_value;
  logic [CNT_W-1:0]         rsp_entry_count;
  logic                     rsp_last;

  logic signed [DATA_W-1:0] cell_q [DEPTH];
  swp_ctrl_t                ctrl;

  logic                     out_free;
  logic                     accept;
  logic [CMP_W-1:0]         pos_c;
  logic [CMP_W-1:0]         cnt_c;
  logic [IDX_W-1:0]         top_idx;
  logic [IDX_W-1:0]         req_sel;
  logic [IDX_W-1:0]         rd_sel;
  logic signed [DATA_W-1:0] rd_value;
  logic                     use_rd;
  logic                     dump_more;
  status_t                  res_status;
  logic [CNT_W-1:0]         cnt_next;

  assign out_free  = !rsp_valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && out_free;
  assign accept    = req.valid && req.ready;

  assign pos_c   = CMP_W'(req.position);
  assign cnt_c   = CMP_W'(fill_count);
  assign top_idx = IDX_W'(fill_count - 1'b1);

  // Decode the request against the current count. Only a request that is
  // accepted and succeeds is allowed to move the cell row.
  always_comb begin
    ctrl       = '0;
    ctrl.value = req.push_value;
    res_status = ST_OK;
    req_sel    = top_idx;
    use_rd     = 1'b0;
    dump_more  = 1'b0;
    cnt_next   = fill_count;
    case (req.req_type)
      REQ_PUSH: begin
        if (cnt_c >= CMP_W'(DEPTH)) begin
          res_status = ST_FULL;
        end else begin
          ctrl.ins = 1'b1;
          ctrl.idx = IDX_W'(fill_count);
          cnt_next = fill_count + 1'b1;
        end
      end
      REQ_POP: begin
        if (fill_count == '0) begin
          res_status = ST_EMPTY;
        end else begin
          ctrl.rem = 1'b1;
          ctrl.idx = top_idx;
          use_rd   = 1'b1;
          cnt_next = fill_count - 1'b1;
        end
      end
      REQ_PEEK: begin
        if (fill_count == '0) begin
          res_status = ST_EMPTY;
        end else begin
          use_rd = 1'b1;
        end
      end
      REQ_INSERT: begin
        // The position check takes priority over the full check.
        if (pos_c > cnt_c) begin
          res_status = ST_INVALID;
        end else if (cnt_c >= CMP_W'(DEPTH)) begin
          res_status = ST_FULL;
        end else begin
          ctrl.ins = 1'b1;
          ctrl.idx = IDX_W'(pos_c);
          cnt_next = fill_count + 1'b1;
        end
      end
      REQ_REMOVE: begin
        if (fill_count == '0) begin
          res_status = ST_EMPTY;
        end else if (pos_c >= cnt_c) begin
          res_status = ST_INVALID;
        end else begin
          // The position counts from the top; turn it into a slot index.
          ctrl.rem = 1'b1;
          ctrl.idx = IDX_W'(cnt_c - pos_c - 1'b1);
          req_sel  = IDX_W'(cnt_c - pos_c - 1'b1);
          use_rd   = 1'b1;
          cnt_next = fill_count - 1'b1;
        end
      end
      REQ_DUMP: begin
        if (fill_count == '0) begin
          res_status = ST_EMPTY;
        end else begin
          use_rd    = 1'b1;
          dump_more = (fill_count > CNT_W'(1));
        end
      end
      default: begin
        res_status = ST_INVALID;
      end
    endcase
    ctrl.ins = ctrl.ins && accept;
    ctrl.rem = ctrl.rem && accept;
  end

  // One read port on the row: the request's slot, or the dump pointer.
  assign rd_sel   = (state == S_DUMP) ? dump_idx : req_sel;
  assign rd_value = cell_q[rd_sel];

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic signed [DATA_W-1:0] below_d;
      logic signed [DATA_W-1:0] above_d;
      if (gi == 0) begin : g_bot
        assign below_d = '0;
      end else begin : g_mid_lo
        assign below_d = cell_q[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_top
        assign above_d = '0;
      end else begin : g_mid_hi
        assign above_d = cell_q[gi+1];
      end
      swp_cell u_cell (
        .clk      (clk),
        .cell_idx (IDX_W'(gi)),
        .ctrl     (ctrl),
        .below    (below_d),
        .above    (above_d),
        .data     (cell_q[gi])
      );
    end
  endgenerate

  // A dump of more than one entry gives its first result from the idle state
  // and then walks the dump pointer down to slot 0, one result each time the
  // output register frees up.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            rsp_valid       <= 1'b1;
            rsp_status      <= res_status;
            rsp_read_value  <= use_rd ? rd_value : '0;
            rsp_entry_count <= cnt_next;
            rsp_last        <= !dump_more;
            fill_count      <= cnt_next;
            if (dump_more) begin
              state    <= S_DUMP;
              dump_idx <= top_idx - 1'b1;
            end
          end else if (rsp.ready) begin
            rsp_valid <= 1'b0;
          end
        end
        S_DUMP: begin
          if (out_free) begin
            rsp_valid       <= 1'b1;
            rsp_status      <= ST_OK;
            rsp_read_value  <= rd_value;
            rsp_entry_count <= fill_count;
            rsp_last        <= (dump_idx == '0);
            dump_idx        <= dump_idx - 1'b1;
            if (dump_idx == '0) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.read_value  = rsp_read_value;
  assign rsp.entry_count = rsp_entry_count;
  assign rsp.last        = rsp_last;

  // The count never passes the number of slots.
  `SWP_ASSERT_SAME(a_count_bound, 1'b1, fill_count <= CNT_W'(DEPTH),
                   "stack count exceeds depth")
  // A successful push raises the count by exactly one.
  `SWP_ASSERT_NEXT(a_push_count,
                   accept && (req.req_type == REQ_PUSH) && (res_status == ST_OK),
                   fill_count == $past(fill_count) + 1'b1,
                   "push did not advance the count")
  // A result taken without the last mark is followed at once by another one.
  `SWP_ASSERT_NEXT(a_dump_continues, rsp.valid && rsp.ready && !rsp.last,
                   rsp.valid, "dump result stream broke off")
  // No request is taken while a dump is still being delivered.
  `SWP_ASSERT_SAME(a_dump_blocks, state == S_DUMP, !req.ready,
                   "request accepted during a dump")

endmodule

`default_nettype wire

[dv/tb_stack_with_positional_insert_remove_top.sv]
module tb_stack_with_positional_insert_remove_top;
  timeunit 1ns;
  timeprecision 1ps;

  import swp_pkg::*;

  // The two request codes that the package leaves unused. The block must answer
  // each of them with an invalid status and leave the stack alone.
  localparam logic [2:0] REQ_SPARE_LO = 3'd6;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;

  // The limit leaves ample room for the slowest correct run: about 300 requests, each
  // at worst a full dump of 16 results, with the receiver stalling half the time.
  localparam int CYCLE_LIMIT = 200_000;
  localparam int ITEMS_PER_PHASE = 65;
  localparam int N_DIRECTED = 26;

  // One result word as the stack is expected to answer it.
  typedef struct {
    status_t                  status;
    logic signed [DATA_W-1:0] value;
    int unsigned              count;
    bit                       last;
  } stack_result_t;

  // One row of the directed table. A row with reps above one repeats its
  // request with a fresh random word each time. Rows marked typed carry the
  // single result that they must produce; the other rows rely on the
  // shadow stack.
  typedef struct {
    logic [2:0]               op;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] word;
    int                       reps;
    bit                       typed;
    status_t                  status;
    logic signed [DATA_W-1:0] read_word;
    int unsigned              count;
  } directed_row_t;

  logic clk;
  logic rst;

  swp_req_if req_ch ();
  swp_rsp_if rsp_ch ();

  stack_with_positional_insert_remove_top dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Shadow copy of the stack. Slot 0 is the bottom, as in the block.
  logic signed [DATA_W-1:0] shadow_mem [DEPTH];
  int unsigned              shadow_count;

  // Results that the stack still owes us, oldest first.
  stack_result_t awaited_results [$];

  directed_row_t directed_rows [N_DIRECTED];

  int sender_idle_pct;
  int receiver_stall_pct;
  int mismatch_count;
  int cycle_count;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: a lost result or a hung handshake ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_stack_with_positional_insert_remove_top NOT OK");
      $finish;
    end
  end

  // The receiver stalls at random, at whatever rate the current phase sets.
  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  function automatic void await_result(status_t status, logic signed [DATA_W-1:0] value,
                                       bit last);
    stack_result_t r;
    r.status = status;
    r.value  = value;
    r.count  = shadow_count;
    r.last   = last;
    awaited_results.push_back(r);
  endfunction

  // Applies one accepted request to the shadow stack and queues the results
  // that it must produce, in order.
  function automatic void step_shadow_stack(logic [2:0] op, logic [POS_W-1:0] pos,
                                            logic signed [DATA_W-1:0] word);
    int unsigned              i;
    logic signed [DATA_W-1:0] taken;
    case (op)
      REQ_PUSH: begin
        if (shadow_count >= DEPTH) begin
          await_result(ST_FULL, '0, 1'b1);
        end else begin
          shadow_mem[shadow_count] = word;
          shadow_count++;
          await_result(ST_OK, '0, 1'b1);
        end
      end
      REQ_POP: begin
        if (shadow_count == 0) begin
          await_result(ST_EMPTY, '0, 1'b1);
        end else begin
          shadow_count--;
          await_result(ST_OK, shadow_mem[shadow_count], 1'b1);
        end
      end
      REQ_PEEK: begin
        if (shadow_count == 0) await_result(ST_EMPTY, '0, 1'b1);
        else await_result(ST_OK, shadow_mem[shadow_count-1], 1'b1);
      end
      REQ_INSERT: begin
        // The position is checked before fullness.
        if (pos > shadow_count) begin
          await_result(ST_INVALID, '0, 1'b1);
        end else if (shadow_count >= DEPTH) begin
          await_result(ST_FULL, '0, 1'b1);
        end else begin
          for (i = shadow_count; i > pos; i--) shadow_mem[i] = shadow_mem[i-1];
          shadow_mem[pos] = word;
          shadow_count++;
          await_result(ST_OK, '0, 1'b1);
        end
      end
      REQ_REMOVE: begin
        if (shadow_count == 0) begin
          await_result(ST_EMPTY, '0, 1'b1);
        end else if (pos >= shadow_count) begin
          await_result(ST_INVALID, '0, 1'b1);
        end else begin
          i = shadow_count - 1 - pos;
          taken = shadow_mem[i];
          for (; i + 1 < shadow_count; i++) shadow_mem[i] = shadow_mem[i+1];
          shadow_count--;
          await_result(ST_OK, taken, 1'b1);
        end
      end
      REQ_DUMP: begin
        if (shadow_count == 0) begin
          await_result(ST_EMPTY, '0, 1'b1);
        end else begin
          for (i = 0; i < shadow_count; i++)
            await_result(ST_OK, shadow_mem[shadow_count-1-i], i + 1 == shadow_count);
        end
      end
      default: await_result(ST_INVALID, '0, 1'b1);
    endcase
  endfunction

  // Mostly arbitrary words, with the sign extremes, zero and minus one mixed in.
  function automatic logic signed [DATA_W-1:0] pick_word();
    case ($urandom_range(9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'sh0000_0000;
      3: return 32'shffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Offers one request, after a random gap, and holds it until the stack takes
  // it. Valid stays high on return, so back-to-back requests leave no bubble.
  task automatic issue_request(logic [2:0] op, logic [POS_W-1:0] pos,
                               logic signed [DATA_W-1:0] word);
    while ($urandom_range(99) < sender_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= op;
    req_ch.position   <= pos;
    req_ch.push_value <= word;
    do @(posedge clk); while (!req_ch.ready);
    step_shadow_stack(op, pos, word);
  endtask

  // Stops offering requests until every awaited result has come back.
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  // Every accepted result is checked against the oldest awaited one.
  always @(posedge clk) begin : check_results
    stack_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result: status %0d, read_value %0d, entry_count %0d",
                 $time, rsp_ch.status, rsp_ch.read_value, rsp_ch.entry_count);
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        if (rsp_ch.status !== want.status) begin
          $display("%0t: status: expected %0d, actual %0d", $time, want.status,
                   rsp_ch.status);
          mismatch_count++;
        end
        if (rsp_ch.read_value !== want.value) begin
          $display("%0t: read_value: expected %0d, actual %0d", $time, want.value,
                   rsp_ch.read_value);
          mismatch_count++;
        end
        if (rsp_ch.entry_count !== want.count[CNT_W-1:0]) begin
          $display("%0t: entry_count: expected %0d, actual %0d", $time, want.count,
                   rsp_ch.entry_count);
          mismatch_count++;
        end
        if (rsp_ch.last !== want.last) begin
          $display("%0t: last: expected %0b, actual %0b", $time, want.last, rsp_ch.last);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : stimulus
    stack_result_t    typed_result;
    logic [2:0]       op;
    logic [POS_W-1:0] pos;
    int               r;
    int               phase;
    int               n;
    int               k;
    bit               growing;

    rst                <= 1'b1;
    req_ch.valid       <= 1'b0;
    req_ch.req_type    <= REQ_PUSH;
    req_ch.position    <= '0;
    req_ch.push_value  <= '0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    mismatch_count     = 0;
    cycle_count        = 0;
    shadow_count       = 0;

    // Directed walk. It starts on the empty stack, builds a small stack with
    // both sign extremes at the bottom and top, probes positions on each side
    // of the legal range, then fills the stack to the brim and dumps it.
    directed_rows = '{
      '{REQ_POP,      5'd0,  32'sd0,           1, 1'b1, ST_EMPTY,   32'sd0,           0},
      '{REQ_PEEK,     5'd0,  32'sd0,           1, 1'b1, ST_EMPTY,   32'sd0,           0},
      '{REQ_REMOVE,   5'd0,  32'sd0,           1, 1'b1, ST_EMPTY,   32'sd0,           0},
      '{REQ_DUMP,     5'd0,  32'sd0,           1, 1'b1, ST_EMPTY,   32'sd0,           0},
      '{REQ_INSERT,   5'd1,  32'sd5,           1, 1'b1, ST_INVALID, 32'sd0,           0},
      '{REQ_SPARE_LO, 5'd0,  32'sd0,           1, 1'b1, ST_INVALID, 32'sd0,           0},
      '{REQ_SPARE_HI, 5'd31, 32'shffff_ffff,   1, 1'b1, ST_INVALID, 32'sd0,           0},
      '{REQ_PUSH,     5'd31, 32'sh8000_0000,   1, 1'b1, ST_OK,      32'sd0,           1},
      '{REQ_PUSH,     5'd0,  32'sh7fff_ffff,   1, 1'b1, ST_OK,      32'sd0,           2},
      '{REQ_PEEK,     5'd0,  32'sd0,           1, 1'b1, ST_OK,      32'sh7fff_ffff,   2},
      '{REQ_INSERT,   5'd0,  32'shffff_ffff,   1, 1'b1, ST_OK,      32'sd0,           3},
      '{REQ_INSERT,   5'd3,  32'sd1,           1, 1'b1, ST_OK,      32'sd0,           4},
      '{REQ_REMOVE,   5'd4,  32'sd0,           1, 1'b1, ST_INVALID, 32'sd0,           4},
      '{REQ_REMOVE,   5'd31, 32'sd0,           1, 1'b1, ST_INVALID, 32'sd0,           4},
      '{REQ_INSERT,   5'd31, 32'sd9,           1, 1'b1, ST_INVALID, 32'sd0,           4},
      '{REQ_DUMP,     5'd0,  32'sd0,           1, 1'b0, ST_OK,      32'sd0,           0},
      '{REQ_REMOVE,   5'd3,  32'sd0,           1, 1'b1, ST_OK,      32'shffff_ffff,   3},
      '{REQ_REMOVE,   5'd0,  32'sd0,           1, 1'b1, ST_OK,      32'sd1,           2},
      '{REQ_POP,      5'd0,  32'sd0,           1, 1'b1, ST_OK,      32'sh7fff_ffff,   1},
      '{REQ_PUSH,     5'd0,  32'sd0,          15, 1'b0, ST_OK,      32'sd0,           0},
      '{REQ_PUSH,     5'd0,  32'sd3,           1, 1'b1, ST_FULL,    32'sd0,          16},
      '{REQ_INSERT,   5'd16, 32'sd3,           1, 1'b1, ST_FULL,    32'sd0,          16},
      '{REQ_INSERT,   5'd17, 32'sd3,           1, 1'b1, ST_INVALID, 32'sd0,          16},
      '{REQ_DUMP,     5'd0,  32'sd0,           1, 1'b0, ST_OK,      32'sd0,           0},
      '{REQ_REMOVE,   5'd15, 32'sd0,           1, 1'b1, ST_OK,      32'sh8000_0000,  15},
      '{REQ_REMOVE,   5'd7,  32'sd0,           1, 1'b0, ST_OK,      32'sd0,           0}
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (n = 0; n < N_DIRECTED; n++) begin
      for (k = 0; k < directed_rows[n].reps; k++) begin
        issue_request(directed_rows[n].op, directed_rows[n].pos,
                      directed_rows[n].reps > 1 ? pick_word() : directed_rows[n].word);
        // A typed row answers with exactly one result; the hand-written one
        // takes the place of the predicted one.
        if (directed_rows[n].typed) begin
          typed_result.status = directed_rows[n].status;
          typed_result.value  = directed_rows[n].read_word;
          typed_result.count  = directed_rows[n].count;
          typed_result.last   = 1'b1;
          void'(awaited_results.pop_back());
          awaited_results.push_back(typed_result);
        end
      end
    end
    drain_results();

    // Random part in four phases: no idling, a slow sender, a slow receiver,
    // then light idling on both sides. Between phases the sender holds off
    // until the stack has answered everything.
    growing = 1'b1;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 54; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 54; end
        default: begin sender_idle_pct = 10; receiver_stall_pct = 10; end
      endcase
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        // The stack trends up for a while, then down, so it keeps running
        // into both the full and the empty case.
        if (n % 30 == 0) growing = ~growing;
        r = $urandom_range(99);
        if (r < 4) begin
          op = (r % 2 == 0) ? REQ_SPARE_LO : REQ_SPARE_HI;
        end else if (r < 10) begin
          op = REQ_DUMP;
        end else if (r < 18) begin
          op = REQ_PEEK;
        end else if (r < 59) begin
          if (growing) op = (r < 40) ? REQ_PUSH : REQ_INSERT;
          else op = (r < 40) ? REQ_POP : REQ_REMOVE;
        end else begin
          case ($urandom_range(3))
            0: op = REQ_PUSH;
            1: op = REQ_POP;
            2: op = REQ_INSERT;
            default: op = REQ_REMOVE;
          endcase
        end
        // Positions are mostly legal for the current fill, with a share of
        // arbitrary ones that reach every bit of the field.
        if ($urandom_range(99) < 15) pos = POS_W'($urandom_range(31));
        else if (op == REQ_INSERT) pos = POS_W'($urandom_range(shadow_count));
        else if (op == REQ_REMOVE && shadow_count > 0)
          pos = POS_W'($urandom_range(shadow_count - 1));
        else pos = POS_W'($urandom_range(31));
        issue_request(op, pos, pick_word());
      end
      drain_results();
    end

    // A result is registered in the cycle after its request is accepted; the wait
    // below leaves room for anything stray to show up.
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("tb_stack_with_positional_insert_remove_top OK");
    end else begin
      $display("tb_stack_with_positional_insert_remove_top NOT OK");
    end
    $finish;
  end

endmodule
